// ===== sv/spq_pkg.sv =====
// Shared constants, operation codes and controller-to-datapath types for the sorted queue.
package spq_pkg;

  // Queue geometry and field widths.
  localparam int unsigned SPQ_DEPTH = 16;
  localparam int unsigned CNT_W     = $clog2(SPQ_DEPTH + 1);
  localparam int unsigned IDX_W     = $clog2(SPQ_DEPTH);
  localparam int unsigned KEY_W     = 16;
  localparam int unsigned TAG_W     = 8;
  localparam int unsigned FUNC_W    = 2;

  // Operation codes carried in the func field.
  localparam logic [FUNC_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [FUNC_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [FUNC_W-1:0] OP_CLEAR   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic execute;  // apply the latched request and load the result register
  } spq_cmd_t;

endpackage

// ===== sv/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: controller and datapath.
//
//   channel   direction  handshake                  payload
//   request   in         in_valid_i / in_stall_o    func_i, key_i, tag_i, remove_count_i
//   result    out        out_valid_o / out_stall_i  occupancy_o, head_valid_o, head_key_o,
//                                                   head_tag_o, dropped_o
//
// Each request is first latched, then executed: every slot cell compares
// against the key and shifts by a selected amount in parallel.
// A request is accepted while a previous result still waits in the output register;
// execution holds only if that register is still occupied and stalled.
// Reset (rst_ni low, asynchronous) empties the queue; slot contents are not cleared.
// There is one result per request.
module sorted_priority_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [spq_pkg::FUNC_W-1:0]   func_i,
  input  logic [spq_pkg::KEY_W-1:0]    key_i,
  input  logic [spq_pkg::TAG_W-1:0]    tag_i,
  input  logic [spq_pkg::CNT_W-1:0]    remove_count_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [spq_pkg::CNT_W-1:0]    occupancy_o,
  output logic                         head_valid_o,
  output logic [spq_pkg::KEY_W-1:0]    head_key_o,
  output logic [spq_pkg::TAG_W-1:0]    head_tag_o,
  output logic                         dropped_o
);

  spq_pkg::spq_cmd_t cmd;

  // Sequencing of requests and results.
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // Slot cells and result register.
  spq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .func_i         (func_i),
    .key_i          (key_i),
    .tag_i          (tag_i),
    .remove_count_i (remove_count_i),
    .occupancy_o    (occupancy_o),
    .head_valid_o   (head_valid_o),
    .head_key_o     (head_key_o),
    .head_tag_o     (head_tag_o),
    .dropped_o      (dropped_o)
  );

endmodule

// ===== sv/spq_ctrl.sv =====
// Controller state machine for the sorted queue: request acceptance and result handoff.
module spq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output spq_pkg::spq_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic out_free;

  // A new request is taken only while no request is being worked on.
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // The result register can be loaded when it is empty or drains this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd_o.execute = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // An accepted request always moves the controller to execute in the following cycle.
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC))
    else $error("accepted request did not move the controller to execute");

  // Executing a request always presents its result next cycle.
  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |=> (out_valid_q && state_q == ST_IDLE))
    else $error("executed request did not produce a result");

  // Execution never overwrites a result that is still held.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while stalled");
`endif

endmodule

// ===== sv/spq_datapath.sv =====
// Datapath for the sorted queue: slot cells, entry count, request and result registers.
module spq_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  spq_pkg::spq_cmd_t            cmd_i,
  input  logic [spq_pkg::FUNC_W-1:0]   func_i,
  input  logic [spq_pkg::KEY_W-1:0]    key_i,
  input  logic [spq_pkg::TAG_W-1:0]    tag_i,
  input  logic [spq_pkg::CNT_W-1:0]    remove_count_i,
  output logic [spq_pkg::CNT_W-1:0]    occupancy_o,
  output logic                         head_valid_o,
  output logic [spq_pkg::KEY_W-1:0]    head_key_o,
  output logic [spq_pkg::TAG_W-1:0]    head_tag_o,
  output logic                         dropped_o
);

  // Latched request.
  logic [spq_pkg::FUNC_W-1:0] func_q;
  logic [spq_pkg::KEY_W-1:0]  key_q;
  logic [spq_pkg::TAG_W-1:0]  tag_q;
  logic [spq_pkg::CNT_W-1:0]  rmv_q;

  // Slot cells, head at index zero.
  logic [spq_pkg::KEY_W-1:0] slot_key_q [spq_pkg::SPQ_DEPTH];
  logic [spq_pkg::TAG_W-1:0] slot_tag_q [spq_pkg::SPQ_DEPTH];
  logic [spq_pkg::KEY_W-1:0] slot_key_d [spq_pkg::SPQ_DEPTH];
  logic [spq_pkg::TAG_W-1:0] slot_tag_d [spq_pkg::SPQ_DEPTH];
  logic [spq_pkg::CNT_W-1:0] count_q, count_d;

  // Result register.
  logic [spq_pkg::CNT_W-1:0] occupancy_q;
  logic                      head_valid_q;
  logic [spq_pkg::KEY_W-1:0] head_key_q;
  logic [spq_pkg::TAG_W-1:0] head_tag_q;
  logic                      dropped_q;

  // Per-cell compare results and dequeue shift amount.
  logic [spq_pkg::SPQ_DEPTH-1:0] stay;
  logic [spq_pkg::CNT_W-1:0]     shift_n;
  logic                          queue_full;
  logic                          do_insert;
  logic                          drop;
  logic [spq_pkg::CNT_W:0]       src_idx [spq_pkg::SPQ_DEPTH];

  assign queue_full = (count_q == spq_pkg::CNT_W'(spq_pkg::SPQ_DEPTH));
  assign do_insert  = (func_q == spq_pkg::OP_INSERT) && (key_q != '0) && !queue_full;
  assign drop       = (func_q == spq_pkg::OP_INSERT) && (key_q != '0) && queue_full;
  assign shift_n    = (rmv_q > count_q) ? count_q : rmv_q;

  // A cell keeps its entry on insert when it is occupied and its key is not lower.
  always_comb begin
    for (int i = 0; i < int'(spq_pkg::SPQ_DEPTH); i++) begin
      stay[i]    = (spq_pkg::CNT_W'(i) < count_q) && (slot_key_q[i] >= key_q);
      src_idx[i] = (spq_pkg::CNT_W + 1)'(i) + {1'b0, shift_n};
    end
  end

  // Next contents of every cell for the latched operation.
  always_comb begin
    count_d = count_q;
    for (int i = 0; i < int'(spq_pkg::SPQ_DEPTH); i++) begin
      slot_key_d[i] = slot_key_q[i];
      slot_tag_d[i] = slot_tag_q[i];
    end
    case (func_q)
      spq_pkg::OP_INSERT: begin
        if (do_insert) begin
          count_d = count_q + 1'b1;
          for (int i = 0; i < int'(spq_pkg::SPQ_DEPTH); i++) begin
            if (!stay[i]) begin
              if (i == 0) begin
                slot_key_d[i] = key_q;
                slot_tag_d[i] = tag_q;
              end else if (stay[(i == 0) ? 0 : i - 1]) begin
                slot_key_d[i] = key_q;
                slot_tag_d[i] = tag_q;
              end else begin
                slot_key_d[i] = slot_key_q[(i == 0) ? 0 : i - 1];
                slot_tag_d[i] = slot_tag_q[(i == 0) ? 0 : i - 1];
              end
            end
          end
        end
      end
      spq_pkg::OP_DEQUEUE: begin
        count_d = count_q - shift_n;
        for (int i = 0; i < int'(spq_pkg::SPQ_DEPTH); i++) begin
          if (src_idx[i] < (spq_pkg::CNT_W + 1)'(spq_pkg::SPQ_DEPTH)) begin
            slot_key_d[i] = slot_key_q[src_idx[i][spq_pkg::IDX_W-1:0]];
            slot_tag_d[i] = slot_tag_q[src_idx[i][spq_pkg::IDX_W-1:0]];
          end
        end
      end
      spq_pkg::OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  // Entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  // Request latch, slot cells and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      key_q  <= key_i;
      tag_q  <= tag_i;
      rmv_q  <= remove_count_i;
    end
    if (cmd_i.execute) begin
      for (int i = 0; i < int'(spq_pkg::SPQ_DEPTH); i++) begin
        slot_key_q[i] <= slot_key_d[i];
        slot_tag_q[i] <= slot_tag_d[i];
      end
      occupancy_q  <= count_d;
      head_valid_q <= (count_d != '0);
      head_key_q   <= (count_d != '0) ? slot_key_d[0] : '0;
      head_tag_q   <= (count_d != '0) ? slot_tag_d[0] : '0;
      dropped_q    <= drop;
    end
  end

  assign occupancy_o  = occupancy_q;
  assign head_valid_o = head_valid_q;
  assign head_key_o   = head_key_q;
  assign head_tag_o   = head_tag_q;
  assign dropped_o    = dropped_q;

`ifndef SYNTHESIS
  // The queue never holds more entries than it has cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= spq_pkg::CNT_W'(spq_pkg::SPQ_DEPTH))
    else $error("entry count exceeds queue depth");

  // The entry count only moves when a request is executed.
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.execute |=> $stable(count_q))
    else $error("entry count changed without an executed request");
`endif

endmodule
